// File: sv/aso_pkg.sv
// shared types and constants for the angle and speed observer
// no dependencies; imported by aso_serial_mul and angle_speed_observer
`timescale 1ns / 1ps
`default_nettype none

package aso_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned AngleW   = 16;
  localparam int unsigned ErrSteps = 16;
  localparam int unsigned DtSteps  = 32;
  localparam int unsigned CntW     = 5;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned WideW    = 50;

  // configuration register indexes
  localparam logic [IdxW-1:0] RegStepTime       = 3'd0;
  localparam logic [IdxW-1:0] RegAngleGain      = 3'd1;
  localparam logic [IdxW-1:0] RegSpeedGain      = 3'd2;
  localparam logic [IdxW-1:0] RegDisturbGain    = 3'd3;
  localparam logic [IdxW-1:0] RegDriveGain      = 3'd4;

  typedef enum logic [2:0] {
    StIdle,
    StMulErr,
    StSum,
    StMulDt,
    StUpdate,
    StOutput
  } aso_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic neg;
  } aso_mul_ctrl_t;

  localparam logic signed [WideW-1:0] SatMax = WideW'(64'sd2147483647);
  localparam logic signed [WideW-1:0] SatMin = -WideW'(64'sd2147483648);

  // clamp a wide signed value to the signed 32 bit range
  function automatic logic [WordW-1:0] sat32(input logic signed [WideW-1:0] x);
    logic [WordW-1:0] r;
    if (x > SatMax) begin
      r = 32'h7fff_ffff;
    end else if (x < SatMin) begin
      r = 32'h8000_0000;
    end else begin
      r = x[WordW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/angle_speed_observer.sv
// third order angle / speed / disturbance observer, top level
// depends on aso_pkg and aso_serial_mul
//
//  channel  signals                                   dir
//  in       in_valid_i/in_ready_o, measured_angle_i,   in
//           drive_value_i
//  out      out_valid_o/out_ready_i, speed_estimate_o,  out
//           speed_rpm_o, disturbance_estimate_o, angle_estimate_o
//  cfg      cfg_valid_i/cfg_ready_o, cfg_index_i,       in
//           cfg_data_i
//
// a word accepted in StIdle runs 16 serial error-product steps, a derivative sum,
// 32 serial step-time steps, a state update and an output load before its result
// is valid; one word at a time, since in_ready_o is high only in StIdle
// reset clears all but the output data registers; no clearing pass.
// a result waiting on out_ready_i holds the next word in its last cycle only.
`timescale 1ns / 1ps
`default_nettype none

module angle_speed_observer import aso_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [AngleW-1:0]        measured_angle_i,
  input  logic signed [AngleW-1:0] drive_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [WordW-1:0]  speed_estimate_o,
  output logic signed [WordW-1:0]  speed_rpm_o,
  output logic signed [WordW-1:0]  disturbance_estimate_o,
  output logic [AngleW-1:0]        angle_estimate_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [IdxW-1:0]          cfg_index_i,
  input  logic [WordW-1:0]         cfg_data_i
);

  aso_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [WordW-1:0] step_time_q, angle_gain_q, speed_gain_q, dist_gain_q, drive_gain_q;
  logic [WordW-1:0] angle_q, speed_q, dist_q;
  logic [WordW-1:0] angle_d, speed_d, dist_d;

  logic              out_valid_q;
  logic [WordW-1:0]  out_speed_q, out_rpm_q, out_dist_q;
  logic [AngleW-1:0] out_angle_q;

  aso_mul_ctrl_t mul_ctrl;
  logic          load_out;
  logic          upd_state;

  logic [AngleW-1:0] err;
  logic [WordW-1:0]  mcand0, mcand1, mcand2, mlr_e, mlr_u, mlr_sel0, mlr_sel3;

  logic signed [WordW:0]  acc0, acc1, acc2, acc3;
  logic [WordW-1:0]       lo0, lo1, lo2, lo3;
  logic signed [WideW-1:0] d2_sum;
  logic [WordW-1:0]       d1, d2, d3;
  logic signed [WideW-1:0] rpm_wide;

  // error wraps to a signed half turn, exactly half maps to minus half
  assign err   = measured_angle_i - angle_q[AngleW-1:0];
  assign mlr_e = {{(WordW-AngleW){1'b0}}, err};
  assign mlr_u = {{(WordW-AngleW){1'b0}}, drive_value_i};

  // derivative sums from the error products
  assign d1 = sat32(WideW'($signed(speed_q)) + WideW'(acc0));
  assign d2_sum = WideW'($signed(dist_q)) + WideW'(acc1)
                + WideW'($signed({acc3[WordW-1:0], lo3[WordW-1:AngleW]}));
  assign d2 = sat32(d2_sum);
  assign d3 = sat32(WideW'(acc2));

  always_comb begin
    if (state_q == StIdle) begin
      mcand0   = angle_gain_q;
      mcand1   = speed_gain_q;
      mcand2   = dist_gain_q;
      mlr_sel0 = mlr_e;
      mlr_sel3 = mlr_u;
    end else begin
      mcand0   = d1;
      mcand1   = d2;
      mcand2   = d3;
      mlr_sel0 = step_time_q;
      mlr_sel3 = mlr_u;
    end
  end

  aso_serial_mul u_mul0 (
    .clk_i(clk_i), .ctrl_i(mul_ctrl), .mcand_i(mcand0), .mlr_i(mlr_sel0),
    .acc_o(acc0), .lo_o(lo0)
  );
  aso_serial_mul u_mul1 (
    .clk_i(clk_i), .ctrl_i(mul_ctrl), .mcand_i(mcand1), .mlr_i(mlr_sel0),
    .acc_o(acc1), .lo_o(lo1)
  );
  aso_serial_mul u_mul2 (
    .clk_i(clk_i), .ctrl_i(mul_ctrl), .mcand_i(mcand2), .mlr_i(mlr_sel0),
    .acc_o(acc2), .lo_o(lo2)
  );
  aso_serial_mul u_mul3 (
    .clk_i(clk_i), .ctrl_i(mul_ctrl), .mcand_i(drive_gain_q), .mlr_i(mlr_sel3),
    .acc_o(acc3), .lo_o(lo3)
  );

  // state update after the step-time products, the shifted product sits in acc
  assign angle_d = angle_q + acc0[WordW-1:0];
  assign speed_d = sat32(WideW'($signed(speed_q)) + WideW'(acc1));
  assign dist_d  = sat32(WideW'($signed(dist_q)) + WideW'(acc2));

  // speed times sixty as 64x - 4x
  assign rpm_wide = (WideW'($signed(speed_q)) <<< 6) - (WideW'($signed(speed_q)) <<< 2);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (in_valid_i) state_d = StMulErr;
      end
      StMulErr: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(ErrSteps - 1)) begin
          cnt_d   = '0;
          state_d = StSum;
        end
      end
      StSum: begin
        cnt_d   = '0;
        state_d = StMulDt;
      end
      StMulDt: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(DtSteps - 1)) begin
          cnt_d   = '0;
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        state_d = StOutput;
      end
      StOutput: begin
        if (!out_valid_q || out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o    = 1'b0;
    mul_ctrl      = '0;
    load_out      = 1'b0;
    upd_state     = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        mul_ctrl.load = in_valid_i;
      end
      StMulErr: begin
        mul_ctrl.step = 1'b1;
        mul_ctrl.neg  = (cnt_q == CntW'(ErrSteps - 1));
      end
      StSum: begin
        mul_ctrl.load = 1'b1;
      end
      StMulDt: begin
        mul_ctrl.step = 1'b1;
      end
      StUpdate: begin
        upd_state = 1'b1;
      end
      StOutput: begin
        load_out = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      step_time_q  <= '0;
      angle_gain_q <= '0;
      speed_gain_q <= '0;
      dist_gain_q  <= '0;
      drive_gain_q <= '0;
      angle_q      <= '0;
      speed_q      <= '0;
      dist_q       <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegStepTime:    step_time_q  <= cfg_data_i;
          RegAngleGain:   angle_gain_q <= cfg_data_i;
          RegSpeedGain:   speed_gain_q <= cfg_data_i;
          RegDisturbGain: dist_gain_q  <= cfg_data_i;
          RegDriveGain:   drive_gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (upd_state) begin
        angle_q <= angle_d;
        speed_q <= speed_d;
        dist_q  <= dist_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_speed_q <= speed_q;
      out_rpm_q   <= sat32(rpm_wide);
      out_dist_q  <= dist_q;
      out_angle_q <= angle_q[AngleW-1:0];
    end
  end

  assign cfg_ready_o            = 1'b1;
  assign out_valid_o            = out_valid_q;
  assign speed_estimate_o       = out_speed_q;
  assign speed_rpm_o            = out_rpm_q;
  assign disturbance_estimate_o = out_dist_q;
  assign angle_estimate_o       = out_angle_q;

endmodule

`default_nettype wire

// File: sv/aso_serial_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle while step is set, lsb first
// uses aso_pkg for the control struct; instanced by angle_speed_observer
`timescale 1ns / 1ps
`default_nettype none

module aso_serial_mul import aso_pkg::*; (
  input  logic                    clk_i,
  input  aso_mul_ctrl_t           ctrl_i,
  input  logic [WordW-1:0]        mcand_i,
  input  logic [WordW-1:0]        mlr_i,
  output logic signed [WordW:0]   acc_o,
  output logic [WordW-1:0]        lo_o
);

  logic [WordW-1:0]        mc_q;
  logic signed [WordW:0]   acc_q;
  logic [WordW-1:0]        lo_q;
  logic signed [WordW+1:0] addend;
  logic signed [WordW+1:0] sum;

  always_comb begin
    addend = '0;
    if (lo_q[0]) begin
      // weight of the sign bit of a signed multiplier is negative
      if (ctrl_i.neg) begin
        addend = -$signed({{2{mc_q[WordW-1]}}, mc_q});
      end else begin
        addend = $signed({{2{mc_q[WordW-1]}}, mc_q});
      end
    end
    sum = $signed({acc_q[WordW], acc_q}) + addend;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      acc_q <= '0;
      mc_q  <= mcand_i;
      lo_q  <= mlr_i;
    end else if (ctrl_i.step) begin
      acc_q <= sum[WordW+1:1];
      lo_q  <= {sum[0], lo_q[WordW-1:1]};
    end
  end

  assign acc_o = acc_q;
  assign lo_o  = lo_q;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench for angle_speed_observer: directed rows, then random words
// under random settings, checked against a fixed-point observer model kept here
// depends on aso_pkg and the angle_speed_observer rtl
`timescale 1ns / 1ps

module tb_top;
  import aso_pkg::*;

  localparam int NumRegs    = 5;
  localparam int HoldCycles = 300;
  localparam int StallLimit = 2000;
  localparam int EndPause   = 64;
  localparam int RandPhases = 8;
  localparam int PhaseWords = 150;
  localparam longint Pos32  = 2147483647;
  localparam longint Neg32  = -Pos32 - 1;

  typedef struct packed {
    logic signed [WordW-1:0] speed;
    logic signed [WordW-1:0] rpm;
    logic signed [WordW-1:0] disturb;
    logic [AngleW-1:0]       angle;
  } obs_word_t;

  typedef struct packed {
    logic [WordW-1:0]        dt;
    logic signed [WordW-1:0] g_angle;
    logic signed [WordW-1:0] g_speed;
    logic signed [WordW-1:0] g_disturb;
    logic signed [WordW-1:0] g_drive;
  } obs_cfg_t;

  // rel: angle is an offset from the current angle estimate
  typedef struct packed {
    logic [1:0]        cfg_id;
    logic              rel;
    logic [AngleW-1:0] angle;
    logic [AngleW-1:0] drive;
    logic              known;
    obs_word_t         want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [AngleW-1:0] meas_angle = '0;
  logic signed [AngleW-1:0] drive_val = '0;
  logic sink_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [WordW-1:0] cfg_data = '0;

  logic in_ready, out_valid, cfg_ready;
  logic signed [WordW-1:0] speed_out, rpm_out, disturb_out;
  logic [AngleW-1:0] angle_out;

  // model registers and observer state
  logic [WordW-1:0] dt_model = '0;
  logic signed [WordW-1:0] k_angle = '0, k_speed = '0, k_disturb = '0, k_drive = '0;
  logic [WordW-1:0] est_angle = '0;
  logic signed [WordW-1:0] est_speed = '0, est_disturb = '0;

  obs_word_t expected_estimates [$];
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned idle_cycles = 0;

  obs_cfg_t dir_cfgs [0:3] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    '{32'h0200_0000, 32'h0064_0000, 32'h2710_0000, 32'h7fff_ffff, 32'h8000_0000},
    '{32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
    '{32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0001}
  };

  // states stay zero while the step time is zero, so those rows are typed in
  dir_row_t dir_rows [0:18] = '{
    '{2'd0, 1'b0, 16'h0000, 16'h0000, 1'b1, '0},
    '{2'd0, 1'b0, 16'hffff, 16'h7fff, 1'b1, '0},
    '{2'd0, 1'b0, 16'h8000, 16'h8000, 1'b1, '0},
    '{2'd0, 1'b1, 16'h8000, 16'hffff, 1'b1, '0},
    '{2'd3, 1'b0, 16'h7fff, 16'h8000, 1'b1, '0},
    '{2'd3, 1'b1, 16'h8000, 16'h7fff, 1'b1, '0},
    '{2'd1, 1'b1, 16'h8000, 16'h0000, 1'b0, '0},
    '{2'd1, 1'b1, 16'h7fff, 16'h7fff, 1'b0, '0},
    '{2'd1, 1'b1, 16'h8001, 16'h8000, 1'b0, '0},
    '{2'd1, 1'b1, 16'h0000, 16'h0000, 1'b0, '0},
    '{2'd1, 1'b0, 16'hffff, 16'h0001, 1'b0, '0},
    '{2'd1, 1'b0, 16'h0000, 16'hffff, 1'b0, '0},
    '{2'd2, 1'b0, 16'h5555, 16'h7fff, 1'b0, '0},
    '{2'd2, 1'b0, 16'haaaa, 16'h7fff, 1'b0, '0},
    '{2'd2, 1'b1, 16'h0000, 16'h7fff, 1'b0, '0},
    '{2'd2, 1'b1, 16'h8000, 16'h8000, 1'b0, '0},
    '{2'd2, 1'b0, 16'h0001, 16'h8000, 1'b0, '0},
    '{2'd2, 1'b1, 16'h7fff, 16'h8000, 1'b0, '0},
    '{2'd2, 1'b1, 16'h8000, 16'h0000, 1'b0, '0}
  };

  angle_speed_observer dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .measured_angle_i       (meas_angle),
    .drive_value_i          (drive_val),
    .out_valid_o            (out_valid),
    .out_ready_i            (sink_ready),
    .speed_estimate_o       (speed_out),
    .speed_rpm_o            (rpm_out),
    .disturbance_estimate_o (disturb_out),
    .angle_estimate_o       (angle_out),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp32(input longint x);
    if (x > Pos32) return Pos32;
    if (x < Neg32) return Neg32;
    return x;
  endfunction

  // one euler step of the observer; derivatives use the old states
  function automatic obs_word_t advance_observer(input logic [AngleW-1:0] meas,
                                                 input logic signed [AngleW-1:0] u);
    logic [AngleW-1:0] diff;
    longint e, z2, z3, dtl, d1, d2, d3, i1, i2, i3, t;
    obs_word_t r;
    diff = meas - est_angle[AngleW-1:0];
    e = $signed(diff);
    z2 = est_speed;
    z3 = est_disturb;
    dtl = longint'(dt_model);
    d1 = clamp32(z2 + ((longint'(k_angle) * e) >>> 16));
    d2 = clamp32(z3 + longint'(k_drive) * longint'(u) + ((longint'(k_speed) * e) >>> 16));
    d3 = clamp32((longint'(k_disturb) * e) >>> 16);
    i1 = (d1 * dtl) >>> 32;
    i2 = (d2 * dtl) >>> 32;
    i3 = (d3 * dtl) >>> 32;
    est_angle = est_angle + i1[WordW-1:0];
    t = clamp32(z2 + i2);
    est_speed = t[WordW-1:0];
    t = clamp32(z3 + i3);
    est_disturb = t[WordW-1:0];
    t = clamp32(longint'(est_speed) * 60);
    r.speed = est_speed;
    r.rpm = t[WordW-1:0];
    r.disturb = est_disturb;
    r.angle = est_angle[AngleW-1:0];
    return r;
  endfunction

  function automatic logic signed [WordW-1:0] rand_gain();
    int g;
    g = $urandom();
    case ($urandom_range(0, 7))
      0: g = 32'h7fff_ffff;
      1: g = 32'h8000_0000;
      default: g = g >>> $urandom_range(0, 24);
    endcase
    return g;
  endfunction

  function automatic obs_cfg_t pick_cfg();
    obs_cfg_t c;
    case ($urandom_range(0, 7))
      0: c.dt = '0;
      1: c.dt = '1;
      default: c.dt = $urandom() >> $urandom_range(0, 31);
    endcase
    c.g_angle = rand_gain();
    c.g_speed = rand_gain();
    c.g_disturb = rand_gain();
    c.g_drive = rand_gain();
    return c;
  endfunction

  function automatic void check_field(input string name, input logic [WordW-1:0] want,
                                      input logic [WordW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // leaves cfg_valid high so back-to-back writes need no second assignment
  task automatic cfg_write(input logic [IdxW-1:0] idx, input logic [WordW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegStepTime:    dt_model = data;
      RegAngleGain:   k_angle = data;
      RegSpeedGain:   k_speed = data;
      RegDisturbGain: k_disturb = data;
      RegDriveGain:   k_drive = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // every word gives one result, so an empty queue means the block is idle
  task automatic apply_cfg(input obs_cfg_t c);
    in_valid <= 1'b0;
    while (expected_estimates.size() != 0) @(posedge clk);
    cfg_write(RegStepTime, c.dt);
    cfg_write(RegAngleGain, c.g_angle);
    cfg_write(IdxW'(NumRegs + $urandom_range(0, 2)), $urandom());
    cfg_write(RegSpeedGain, c.g_speed);
    cfg_write(RegDisturbGain, c.g_disturb);
    cfg_write(RegDriveGain, c.g_drive);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input logic [AngleW-1:0] ang, input logic [AngleW-1:0] drv,
                           input logic known, input obs_word_t want);
    obs_word_t w;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    meas_angle <= ang;
    drive_val <= drv;
    do @(posedge clk); while (!in_ready);
    w = advance_observer(ang, drv);
    if (known) w = want;
    expected_estimates.push_back(w);
    words_sent++;
  endtask

  // result side: short random stalls plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        sink_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        sink_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        sink_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    obs_word_t w;
    if (rst_n && out_valid && sink_ready) begin
      if (expected_estimates.size() == 0) begin
        $display("%0t: result word with nothing expected, speed %h angle %h",
                 $time, speed_out, angle_out);
        errors++;
      end else begin
        w = expected_estimates.pop_front();
        check_field("speed_estimate", w.speed, speed_out);
        check_field("speed_rpm", w.rpm, rpm_out);
        check_field("disturbance_estimate", w.disturb, disturb_out);
        check_field("angle_estimate", {16'h0, w.angle}, {16'h0, angle_out});
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && sink_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == StallLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, StallLimit, expected_estimates.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    logic [1:0] cur_cfg;
    logic [AngleW-1:0] a, d;
    int span, off;
    cur_cfg = 2'd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.cfg_id != cur_cfg) begin
        apply_cfg(dir_cfgs[row.cfg_id]);
        cur_cfg = row.cfg_id;
      end
      a = row.rel ? est_angle[AngleW-1:0] + row.angle : row.angle;
      send_word(a, row.drive, row.known, row.want);
    end

    for (int p = 0; p < RandPhases; p++) begin
      gaps_on = (p < RandPhases - 2);
      apply_cfg(pick_cfg());
      for (int n = 0; n < PhaseWords; n++) begin
        if (p == 3 && n == 40) hold_req = 1'b1;
        // mostly track the estimate closely, with some far jumps and half turns
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            span = 16 << (5 * $urandom_range(0, 2));
            off = int'($urandom_range(0, 2 * span)) - span;
            a = est_angle[AngleW-1:0] + off[AngleW-1:0];
          end
          9: a = est_angle[AngleW-1:0] + 16'h7fff + 16'($urandom_range(0, 2));
          default: a = $urandom();
        endcase
        if ($urandom_range(0, 1)) d = $urandom();
        else d = 16'(int'($urandom_range(0, 200)) - 100);
        send_word(a, d, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (expected_estimates.size() != 0) @(posedge clk);
    repeat (EndPause) @(posedge clk);
    $display("summary: %0d words, %0d results checked, %0d register writes, %0d mismatches",
             words_sent, results_checked, cfg_writes, errors);
    $display("summary: reset state, half-turn errors, saturating gains and step times, %0d-cycle output hold",
             HoldCycles);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
